/* hdl/pfa_pkg.sv */
`default_nettype none
package pfa_pkg;

   localparam int NUM_PAGES = 1024;
   localparam int PAGE_W    = 10;
   localparam int CNT_W     = 11;
   localparam int FLAG_W    = 8;
   localparam int PT_W      = FLAG_W + 1;
   localparam int UF_W      = 5;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam int FL_USED = 5;
   localparam int FL_HEAD = 6;
   localparam int FL_PIN  = 7;

   typedef logic [2:0] cmd_code_type;
   localparam cmd_code_type CMD_ALLOC_ONE = 3'd0;
   localparam cmd_code_type CMD_ALLOC_RUN = 3'd1;
   localparam cmd_code_type CMD_FREE      = 3'd2;
   localparam cmd_code_type CMD_QUERY     = 3'd3;
   localparam cmd_code_type CMD_INIT      = 3'd4;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NO_FREE   = 2'd1;
   localparam status_type ST_NOT_HEAD  = 2'd2;
   localparam status_type ST_BAD_COUNT = 2'd3;

   localparam logic REG_FIRST = 1'b0;
   localparam logic REG_LAST  = 1'b1;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [PAGE_W-1:0] page_number;
      logic [CNT_W-1:0]  run_len;
      logic [UF_W-1:0]   user_flags;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [PAGE_W-1:0] result_page;
      logic              is_ram;
      logic [CNT_W-1:0]  free_count;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0] first_ram_page;
      logic [PAGE_W-1:0] last_ram_page;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_A1_RD, S_A1_WR, S_Q_RD, S_Q_WAIT, S_SCAN, S_REBUILD,
      S_COMPACT, S_MARK, S_F_RD, S_F_CHK, S_DONE
   } state_type;

endpackage
`default_nettype wire

/* hdl/physical_page_frame_allocator.sv */
// Page frame allocator with a free list and a per-page table, both in block RAM.
// Input channel (req_*): one command word per item, valid/stall handshake.
// Result channel (rsp_*): exactly one result word per command, held in an
// output register; a new command is taken while that word still waits.
// One command is worked on at a time; req_stall is high while it runs.
// Steps per command (accept to result register):
//   alloc one: S_A1_RD, S_A1_WR, S_DONE; query: S_Q_RD, S_Q_WAIT, S_DONE;
//   free: S_F_RD and S_F_CHK per page checked (the pages released and the
//   page that ends the walk), then S_DONE; init: a sweep over all pages;
//   alloc run: scan of up to free_count list entries, on a miss a sweep of
//   the whole page table and a second scan, then the list compaction
//   (over the list entries after the run) and a page table write for each
//   page of the run. The single read port of each RAM sets this order.
// Reset: the range registers go to 0 and NUM_PAGES-1 and an init sweep over
// all pages rebuilds both RAMs; no result word comes from it and
// commands stall until it ends. Range writes take effect at the next init.
// A stalled result word holds its value; once the result register is full and
// stalled the block finishes the current command and then waits.
`default_nettype none
module physical_page_frame_allocator (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  pfa_pkg::req_type                 req_word,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output pfa_pkg::rsp_type                 rsp_word,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [pfa_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [pfa_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic      [pfa_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import pfa_pkg::*;

   cfg_type           cfg;
   logic              fl_we, pt_we;
   logic [PAGE_W-1:0] fl_waddr, fl_wdata, fl_raddr, fl_rdata;
   logic [PAGE_W-1:0] pt_waddr, pt_raddr;
   logic [PT_W-1:0]   pt_wdata, pt_rdata;

   pfa_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   pfa_ram #(.DEPTH(NUM_PAGES), .DATA_W(PAGE_W)) u_free_list (
      .clock, .wr_en(fl_we), .wr_addr(fl_waddr), .wr_data(fl_wdata),
      .rd_addr(fl_raddr), .rd_data(fl_rdata)
   );

   pfa_ram #(.DEPTH(NUM_PAGES), .DATA_W(PT_W)) u_page_table (
      .clock, .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
      .rd_addr(pt_raddr), .rd_data(pt_rdata)
   );

   pfa_ctrl u_ctrl (
      .clock, .reset, .cfg, .req_valid, .req_stall, .req_word,
      .rsp_valid, .rsp_stall, .rsp_word,
      .fl_we, .fl_waddr, .fl_wdata, .fl_raddr, .fl_rdata,
      .pt_we, .pt_waddr, .pt_wdata, .pt_raddr, .pt_rdata
   );

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("command accepted while another runs");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.free_count <= CNT_W'(NUM_PAGES))
      else $error("free count above page total");

   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != ST_OK |-> rsp_word.result_page == '0)
      else $error("failed command reports a page");
`endif

endmodule
`default_nettype wire

/* hdl/pfa_ram.sv */
`default_nettype none
module pfa_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 10
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/pfa_csr.sv */
`default_nettype none
module pfa_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [pfa_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [pfa_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [pfa_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready,
   output pfa_pkg::cfg_type                   cfg
);
   import pfa_pkg::*;

   logic [PAGE_W-1:0] first_ff, first_in;
   logic [PAGE_W-1:0] last_ff, last_in;
   logic              wr;

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      if (wr) begin
         if (csr_paddr[2] == REG_LAST) begin
            last_in = csr_pwdata[PAGE_W-1:0];
         end else begin
            first_in = csr_pwdata[PAGE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '1;
      end else begin
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_LAST) ? CSR_DW'(last_ff) : CSR_DW'(first_ff);
   assign cfg.first_ram_page = first_ff;
   assign cfg.last_ram_page  = last_ff;

endmodule
`default_nettype wire

/* hdl/pfa_ctrl.sv */
`default_nettype none
module pfa_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  pfa_pkg::cfg_type                  cfg,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  pfa_pkg::req_type                  req_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output pfa_pkg::rsp_type                  rsp_word,
   output logic                              fl_we,
   output logic [pfa_pkg::PAGE_W-1:0]        fl_waddr,
   output logic [pfa_pkg::PAGE_W-1:0]        fl_wdata,
   output logic [pfa_pkg::PAGE_W-1:0]        fl_raddr,
   input  wire logic [pfa_pkg::PAGE_W-1:0]   fl_rdata,
   output logic                              pt_we,
   output logic [pfa_pkg::PAGE_W-1:0]        pt_waddr,
   output logic [pfa_pkg::PT_W-1:0]          pt_wdata,
   output logic [pfa_pkg::PAGE_W-1:0]        pt_raddr,
   input  wire logic [pfa_pkg::PT_W-1:0]     pt_rdata
);
   import pfa_pkg::*;

   localparam logic [CNT_W-1:0] LAST_PAGE = CNT_W'(NUM_PAGES - 1);
   localparam logic [CNT_W-1:0] ALL_PAGES = CNT_W'(NUM_PAGES);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CNT_W-1:0]  fp_ff, fp_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  dk_ff, dk_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [PAGE_W-1:0] prev_ff, prev_in;
   logic [PAGE_W-1:0] head_ff, head_in;
   logic              pend_ff, pend_in;
   logic              retry_ff, retry_in;
   logic              first_ff, first_in;
   logic              out_en_ff, out_en_in;
   status_type        res_status_ff, res_status_in;
   logic [PAGE_W-1:0] res_page_ff, res_page_in;
   logic              res_ram_ff, res_ram_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              acc;
   logic              scan_cont, scan_found, scan_fail;
   logic [CNT_W-1:0]  len_nx, start_nx;
   logic              rb_add, rb_last;
   logic [CNT_W-1:0]  n_fin;
   logic              in_rng, init_last;
   logic [CNT_W-1:0]  init_n;
   logic              compact_end, mark_last, fr_ok, out_free;
   logic [FLAG_W-1:0] run_flags;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // run search: consecutive page numbers in adjacent list slots
   assign scan_cont  = (len_ff != '0) && ({1'b0, fl_rdata} == {1'b0, prev_ff} + CNT_W'(1));
   assign len_nx     = scan_cont ? len_ff + CNT_W'(1) : CNT_W'(1);
   assign start_nx   = scan_cont ? start_ff : dk_ff;
   assign scan_fail  = pend_ff && !scan_cont && (dk_ff > limit_ff);
   assign scan_found = pend_ff && !scan_fail && (len_nx == req_ff.run_len);

   assign rb_add  = pt_rdata[FLAG_W] && !pt_rdata[FL_USED];
   assign rb_last = pend_ff && (dk_ff == LAST_PAGE);
   assign n_fin   = n_ff + CNT_W'(rb_add);

   assign in_rng    = (k_ff[PAGE_W-1:0] >= cfg.first_ram_page) &&
                      (k_ff[PAGE_W-1:0] <= cfg.last_ram_page);
   assign init_last = (k_ff == LAST_PAGE);
   assign init_n    = n_ff + CNT_W'(in_rng);

   assign compact_end = !pend_ff && (k_ff >= fp_ff);
   assign mark_last   = (k_ff == req_ff.run_len - CNT_W'(1));
   assign fr_ok = first_ff ? (pt_rdata[FL_HEAD] && pt_rdata[FL_USED])
                           : (pt_rdata[FLAG_W] && !pt_rdata[FL_HEAD] && pt_rdata[FL_USED]);

   always_comb begin
      run_flags          = {3'b000, req_ff.user_flags};
      run_flags[FL_USED] = 1'b1;
      run_flags[FL_PIN]  = (req_ff.run_len > CNT_W'(1));
      if (k_ff == '0) begin
         run_flags[FL_HEAD] = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_word.cmd)
                  CMD_ALLOC_ONE: state_in = (fp_ff == '0) ? S_DONE : S_A1_RD;
                  CMD_ALLOC_RUN: begin
                     if (req_word.run_len == '0 || req_word.run_len > fp_ff) begin
                        state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_FREE:  state_in = S_F_RD;
                  CMD_QUERY: state_in = S_Q_RD;
                  CMD_INIT:  state_in = S_INIT;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_INIT:   if (init_last) state_in = out_en_ff ? S_DONE : S_IDLE;
         S_A1_RD:  state_in = S_A1_WR;
         S_A1_WR:  state_in = S_DONE;
         S_Q_RD:   state_in = S_Q_WAIT;
         S_Q_WAIT: state_in = S_DONE;
         S_SCAN: begin
            if (scan_found) begin
               state_in = S_COMPACT;
            end else if (scan_fail) begin
               state_in = retry_ff ? S_DONE : S_REBUILD;
            end
         end
         S_REBUILD: begin
            if (rb_last) state_in = (req_ff.run_len > n_fin) ? S_DONE : S_SCAN;
         end
         S_COMPACT: if (compact_end) state_in = S_MARK;
         S_MARK:    if (mark_last) state_in = S_DONE;
         S_F_RD:    state_in = S_F_CHK;
         S_F_CHK: begin
            if (!fr_ok || k_ff == LAST_PAGE) begin
               state_in = S_DONE;
            end else begin
               state_in = S_F_RD;
            end
         end
         S_DONE:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      req_in        = req_ff;
      fp_in         = fp_ff;
      k_in          = k_ff;
      dk_in         = dk_ff;
      n_in          = n_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      limit_in      = limit_ff;
      prev_in       = prev_ff;
      head_in       = head_ff;
      pend_in       = pend_ff;
      retry_in      = retry_ff;
      first_in      = first_ff;
      out_en_in     = out_en_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_ram_in    = res_ram_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      fl_we         = 1'b0;
      fl_waddr      = '0;
      fl_wdata      = '0;
      fl_raddr      = k_ff[PAGE_W-1:0];
      pt_we         = 1'b0;
      pt_waddr      = '0;
      pt_wdata      = '0;
      pt_raddr      = k_ff[PAGE_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               req_in        = req_word;
               out_en_in     = 1'b1;
               res_status_in = ST_OK;
               res_page_in   = '0;
               res_ram_in    = 1'b0;
               k_in          = '0;
               n_in          = '0;
               len_in        = '0;
               pend_in       = 1'b0;
               retry_in      = 1'b0;
               first_in      = 1'b1;
               limit_in      = fp_ff - req_word.run_len;
               case (req_word.cmd)
                  CMD_ALLOC_ONE: if (fp_ff == '0) res_status_in = ST_NO_FREE;
                  CMD_ALLOC_RUN: begin
                     if (req_word.run_len == '0) begin
                        res_status_in = ST_BAD_COUNT;
                     end else if (req_word.run_len > fp_ff) begin
                        res_status_in = ST_NO_FREE;
                     end
                  end
                  CMD_FREE: k_in = {1'b0, req_word.page_number};
                  default: ;
               endcase
            end
         end
         S_INIT: begin
            pt_we    = 1'b1;
            pt_waddr = k_ff[PAGE_W-1:0];
            pt_wdata = {in_rng, {FLAG_W{1'b0}}};
            fl_we    = in_rng;
            fl_waddr = n_ff[PAGE_W-1:0];
            fl_wdata = k_ff[PAGE_W-1:0];
            n_in     = init_n;
            k_in     = k_ff + CNT_W'(1);
            if (init_last) fp_in = init_n;
         end
         S_A1_RD: fl_raddr = PAGE_W'(fp_ff - CNT_W'(1));
         S_A1_WR: begin
            pt_we              = 1'b1;
            pt_waddr           = fl_rdata;
            pt_wdata           = {1'b1, 3'b000, req_ff.user_flags};
            pt_wdata[FL_USED]  = 1'b1;
            pt_wdata[FL_HEAD]  = 1'b1;
            fp_in              = fp_ff - CNT_W'(1);
            res_page_in        = fl_rdata;
         end
         S_Q_RD:   pt_raddr = req_ff.page_number;
         S_Q_WAIT: res_ram_in = pt_rdata[FLAG_W];
         S_SCAN: begin
            k_in    = k_ff + CNT_W'(1);
            dk_in   = k_ff;
            pend_in = 1'b1;
            if (pend_ff) begin
               prev_in  = fl_rdata;
               len_in   = len_nx;
               start_in = start_nx;
               if (!scan_cont) head_in = fl_rdata;
            end
            if (scan_found) begin
               k_in    = start_nx + req_ff.run_len;
               pend_in = 1'b0;
            end else if (scan_fail) begin
               k_in    = '0;
               n_in    = '0;
               pend_in = 1'b0;
               if (retry_ff) res_status_in = ST_NO_FREE;
            end
         end
         S_REBUILD: begin
            k_in    = k_ff + CNT_W'(1);
            dk_in   = k_ff;
            pend_in = 1'b1;
            if (pend_ff && rb_add) begin
               fl_we    = 1'b1;
               fl_waddr = n_ff[PAGE_W-1:0];
               fl_wdata = dk_ff[PAGE_W-1:0];
               n_in     = n_fin;
            end
            if (rb_last) begin
               fp_in    = n_fin;
               k_in     = '0;
               len_in   = '0;
               pend_in  = 1'b0;
               retry_in = 1'b1;
               limit_in = n_fin - req_ff.run_len;
               if (req_ff.run_len > n_fin) res_status_in = ST_NO_FREE;
            end
         end
         S_COMPACT: begin
            if (pend_ff) begin
               fl_we    = 1'b1;
               fl_waddr = PAGE_W'(dk_ff - req_ff.run_len);
               fl_wdata = fl_rdata;
            end
            if (k_ff < fp_ff) begin
               k_in    = k_ff + CNT_W'(1);
               dk_in   = k_ff;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (compact_end) begin
               fp_in = fp_ff - req_ff.run_len;
               k_in  = '0;
            end
         end
         S_MARK: begin
            pt_we    = 1'b1;
            pt_waddr = head_ff + k_ff[PAGE_W-1:0];
            pt_wdata = {1'b1, run_flags};
            k_in     = k_ff + CNT_W'(1);
            if (mark_last) res_page_in = head_ff;
         end
         S_F_RD: ;
         S_F_CHK: begin
            if (!fr_ok) begin
               if (first_ff) res_status_in = ST_NOT_HEAD;
            end else begin
               pt_we    = 1'b1;
               pt_waddr = k_ff[PAGE_W-1:0];
               pt_wdata = {pt_rdata[FLAG_W], {FLAG_W{1'b0}}};
               if (fp_ff < ALL_PAGES) begin
                  fl_we    = 1'b1;
                  fl_waddr = fp_ff[PAGE_W-1:0];
                  fl_wdata = k_ff[PAGE_W-1:0];
                  fp_in    = fp_ff + CNT_W'(1);
               end
               first_in = 1'b0;
               k_in     = k_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = res_status_ff;
               rsp_in.result_page = res_page_ff;
               rsp_in.is_ram      = res_ram_ff;
               rsp_in.free_count  = fp_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         k_ff         <= '0;
         n_ff         <= '0;
         pend_ff      <= 1'b0;
         out_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fp_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         pend_ff      <= pend_in;
         out_en_ff    <= out_en_in;
         rsp_valid_ff <= rsp_valid_in;
         fp_ff        <= fp_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      dk_ff         <= dk_in;
      len_ff        <= len_in;
      start_ff      <= start_in;
      limit_ff      <= limit_in;
      prev_ff       <= prev_in;
      head_ff       <= head_in;
      retry_ff      <= retry_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_ram_ff    <= res_ram_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none
module tb_top;
   import pfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_word;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   physical_page_frame_allocator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // page allocator shadow
   int unsigned range_lo = 0;
   int unsigned range_hi = 1023;
   int unsigned frame_list [NUM_PAGES];
   bit page_ram [NUM_PAGES];
   logic [FLAG_W-1:0] page_flags [NUM_PAGES];
   int unsigned frames_free;
   int unsigned live_heads [$];

   rsp_type expected_rsp [$];
   int mismatches = 0;
   int rsp_seen = 0;
   int cmds_sent = 0;
   int runs_ok = 0;
   int frees_ok = 0;
   bit quiet = 1'b0;
   int idle_cycles = 0;

   function automatic void shadow_init();
      int unsigned hi;
      hi = (range_hi >= NUM_PAGES) ? NUM_PAGES - 1 : range_hi;
      frames_free = 0;
      live_heads.delete();
      for (int unsigned p = 0; p < NUM_PAGES; p++) begin
         page_flags[p] = '0;
         page_ram[p] = (p >= range_lo) && (p <= hi);
         if (page_ram[p]) begin
            frame_list[frames_free] = p;
            frames_free++;
         end
      end
   endfunction

   function automatic void shadow_rebuild();
      frames_free = 0;
      for (int unsigned p = 0; p < NUM_PAGES; p++) begin
         if (page_ram[p] && !page_flags[p][FL_USED]) begin
            frame_list[frames_free] = p;
            frames_free++;
         end
      end
   endfunction

   function automatic bit first_fit(int unsigned cnt, output int unsigned slot);
      int unsigned i;
      int unsigned j;
      i = 0;
      slot = 0;
      while (cnt <= frames_free && i <= frames_free - cnt) begin
         j = 1;
         while (j < cnt && frame_list[i+j] == frame_list[i+j-1] + 1) j++;
         if (j >= cnt) begin
            slot = i;
            return 1'b1;
         end
         i += j;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type allocate_predict(req_type r);
      rsp_type o;
      int unsigned cnt;
      int unsigned slot;
      int unsigned head;
      int unsigned pg;
      bit found;
      logic [FLAG_W-1:0] fl;
      o = '0;
      cnt = {21'd0, r.run_len};
      case (r.cmd)
         CMD_ALLOC_ONE: begin
            if (frames_free == 0) begin
               o.status = ST_NO_FREE;
            end else begin
               frames_free--;
               pg = frame_list[frames_free];
               page_flags[pg] = {3'b011, r.user_flags};
               o.result_page = PAGE_W'(pg);
               live_heads.push_back(pg);
            end
         end
         CMD_ALLOC_RUN: begin
            if (cnt == 0) begin
               o.status = ST_BAD_COUNT;
            end else if (cnt > frames_free) begin
               o.status = ST_NO_FREE;
            end else begin
               found = first_fit(cnt, slot);
               if (!found) begin
                  shadow_rebuild();
                  found = first_fit(cnt, slot);
               end
               if (!found) begin
                  o.status = ST_NO_FREE;
               end else begin
                  head = frame_list[slot];
                  for (int unsigned k = slot + cnt; k < frames_free; k++)
                     frame_list[k-cnt] = frame_list[k];
                  frames_free -= cnt;
                  fl = {3'b001, r.user_flags};
                  if (cnt > 1) fl[FL_PIN] = 1'b1;
                  for (int unsigned t = 0; t < cnt; t++) begin
                     page_flags[head+t] = fl;
                     if (t == 0) page_flags[head][FL_HEAD] = 1'b1;
                  end
                  o.result_page = PAGE_W'(head);
                  live_heads.push_back(head);
                  runs_ok++;
               end
            end
         end
         CMD_FREE: begin
            pg = {22'd0, r.page_number};
            if (!(page_flags[pg][FL_USED] && page_flags[pg][FL_HEAD])) begin
               o.status = ST_NOT_HEAD;
            end else begin
               foreach (live_heads[i])
                  if (live_heads[i] == pg) begin
                     live_heads.delete(i);
                     break;
                  end
               do begin
                  page_flags[pg] = '0;
                  if (frames_free < NUM_PAGES) begin
                     frame_list[frames_free] = pg;
                     frames_free++;
                  end
                  pg++;
               end while (pg < NUM_PAGES && page_ram[pg] && page_flags[pg][FL_USED]
                          && !page_flags[pg][FL_HEAD]);
               frees_ok++;
            end
         end
         CMD_QUERY: o.is_ram = page_ram[r.page_number];
         CMD_INIT: shadow_init();
         default: ;
      endcase
      o.free_count = frames_free[CNT_W-1:0];
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 8);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_word);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_word.status !== want.status || rsp_word.result_page !== want.result_page
                || rsp_word.is_ram !== want.is_ram
                || rsp_word.free_count !== want.free_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch st/pg/ram/free: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     want.status, want.result_page, want.is_ram, want.free_count,
                     rsp_word.status, rsp_word.result_page, rsp_word.is_ram,
                     rsp_word.free_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired, %0d results pending", expected_rsp.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   task automatic send_cmd(req_type r);
      if (!quiet && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_word <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rsp.push_back(allocate_predict(r));
      cmds_sent++;
   endtask

   task automatic send(cmd_code_type c, int unsigned pg = 0, int unsigned cnt = 0,
                       int unsigned uf = 0);
      req_type r;
      r.cmd = c;
      r.page_number = PAGE_W'(pg);
      r.run_len = CNT_W'(cnt);
      r.user_flags = UF_W'(uf);
      send_cmd(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic addr_reg, int unsigned value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr_reg ? 3'd4 : 3'd0;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr_reg == REG_FIRST) range_lo = value & 10'h3FF;
      else range_hi = value & 10'h3FF;
   endtask

   task automatic set_range(int unsigned lo, int unsigned hi);
      drain();
      csr_write(REG_FIRST, lo);
      csr_write(REG_LAST, hi);
      send(CMD_INIT);
   endtask

   task automatic test_directed();
      send(CMD_ALLOC_ONE, 0, 0, 5'h1F);
      send(CMD_ALLOC_RUN, 0, 4, 5'h0A);
      send(CMD_ALLOC_RUN, 0, 1, 5'h15);
      send(CMD_ALLOC_RUN, 0, 0, 0);
      send(CMD_ALLOC_RUN, 0, 2047, 0);
      send(CMD_ALLOC_RUN, 0, 1024, 0);
      send(CMD_FREE, 2, 0, 0);
      send(CMD_FREE, 0, 0, 0);
      send(CMD_FREE, 1023, 0, 0);
      send(CMD_ALLOC_RUN, 0, 3, 0);
      send(CMD_ALLOC_RUN, 0, 1015, 5'h1F);
      send(CMD_ALLOC_RUN, 0, 1, 0);
      send(CMD_ALLOC_ONE, 0, 0, 0);
      send(CMD_QUERY, 0);
      send(CMD_QUERY, 1023);
      send(3'd5, 1023, 2047, 5'h1F);
      send(3'd6);
      send(3'd7);
      send(CMD_FREE, 4, 0, 0);
      send(CMD_ALLOC_RUN, 0, 8, 3);
      send(CMD_INIT);
   endtask

   task automatic test_ranges();
      set_range(100, 130);
      send(CMD_QUERY, 99);
      send(CMD_QUERY, 100);
      send(CMD_QUERY, 130);
      send(CMD_QUERY, 131);
      send(CMD_ALLOC_RUN, 0, 31, 1);
      send(CMD_ALLOC_ONE);
      send(CMD_FREE, 100);
      send(CMD_ALLOC_ONE);
      set_range(500, 400);
      send(CMD_ALLOC_ONE);
      send(CMD_QUERY, 450);
      set_range(0, 0);
      send(CMD_ALLOC_RUN, 0, 1, 0);
      send(CMD_FREE, 0);
      set_range(1023, 1023);
      send(CMD_ALLOC_ONE, 0, 0, 7);
      send(CMD_FREE, 1023);
   endtask

   task automatic random_item();
      int unsigned roll;
      int unsigned cnt;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         send(CMD_ALLOC_ONE, $urandom_range(0, 1023), 0, $urandom_range(0, 31));
      end else if (roll < 60) begin
         cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 8);
         send(CMD_ALLOC_RUN, $urandom_range(0, 1023), cnt, $urandom_range(0, 31));
      end else if (roll < 85 && live_heads.size() != 0) begin
         send(CMD_FREE, live_heads[$urandom_range(0, live_heads.size() - 1)], 0,
              $urandom_range(0, 31));
      end else if (roll < 92) begin
         send(CMD_FREE, $urandom_range(0, 1023));
      end else if (roll < 98) begin
         send(CMD_QUERY, $urandom_range(0, 1023));
      end else begin
         send(($urandom_range(0, 1)) ? CMD_INIT : cmd_code_type'($urandom_range(5, 7)));
      end
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) random_item();
   endtask

   initial begin
      shadow_init();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_ranges();
      set_range(200, 263);
      test_random(33);
      set_range(0, 1023);
      quiet = 1'b1;
      test_random(33);
      quiet = 1'b0;
      test_random(33);
      drain();
      repeat (20) @(posedge clock);
      $display("%0d commands, %0d results, %0d runs allocated, %0d frees over 6 ranges",
               cmds_sent, rsp_seen, runs_ok, frees_ok);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_top: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
